// File: rtl/hmrf_pkg.sv
`default_nettype none
package hmrf_pkg;

    localparam int REPORT_BYTES_DEF = 64;

    // header byte positions within a report
    localparam logic [2:0] HDR_CID_B0  = 3'd0;
    localparam logic [2:0] HDR_CID_B1  = 3'd1;
    localparam logic [2:0] HDR_CID_B2  = 3'd2;
    localparam logic [2:0] HDR_CID_B3  = 3'd3;
    localparam logic [2:0] HDR_CMD_SEQ = 3'd4;
    localparam logic [2:0] HDR_LEN_HI  = 3'd5;
    localparam logic [2:0] HDR_LEN_LO  = 3'd6;

    typedef enum logic [2:0] {
        PH_NEW,
        PH_HDR_FIRST,
        PH_HDR_CONT,
        PH_DATA,
        PH_PAD
    } phase_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] channel_id;
        logic [7:0]  command;
        logic [15:0] message_length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] report_byte;
        logic       report_end;
        logic       run_last;
    } res_t;

    // header byte at a given report position; cmd_seq is the command for a
    // first report and the sequence number for a continuation report
    function automatic logic [7:0] hdr_byte(
        input logic [2:0]  idx,
        input logic [31:0] cid,
        input logic [7:0]  cmd_seq,
        input logic [15:0] len
    );
        logic [7:0] b;
        case (idx)
            HDR_CID_B0:  b = cid[7:0];
            HDR_CID_B1:  b = cid[15:8];
            HDR_CID_B2:  b = cid[23:16];
            HDR_CID_B3:  b = cid[31:24];
            HDR_CMD_SEQ: b = cmd_seq;
            HDR_LEN_HI:  b = len[15:8];
            HDR_LEN_LO:  b = len[7:0];
            default:     b = 8'd0;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: rtl/hmrf_emitter.sv
`default_nettype none
module hmrf_emitter #(
    parameter int REPORT_BYTES = hmrf_pkg::REPORT_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hmrf_pkg::item_t in_item,
    output logic                res_valid,
    input  wire logic           res_ready,
    output hmrf_pkg::res_t      res
);
    import hmrf_pkg::*;

    localparam int POS_W = $clog2(REPORT_BYTES);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(REPORT_BYTES - 1);

    item_t            item_reg;
    logic             item_valid_reg;
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       seq_reg, seq_next;
    logic [15:0]      sent_reg, sent_next;

    phase_t           start_phase, cur_phase;
    logic [POS_W-1:0] pos_eff, pos_inc, pos_wrap;
    logic             pos_last, fire, load, msg_done;
    logic [15:0]      sent_inc;
    logic [7:0]       hdr_first, hdr_cont;

    assign fire = item_valid_reg && res_ready;
    assign in_ready = !item_valid_reg || (fire && res.run_last);
    // a payload request of a zero-length message produces nothing: drop it
    assign load = in_valid && in_ready &&
                  !(!in_item.kind && (in_item.message_length == 16'd0));

    always_comb
    begin
        if (item_reg.kind)
            start_phase = PH_HDR_FIRST;
        else if (pos_reg != {POS_W{1'b0}})
            start_phase = PH_DATA;
        else if (sent_reg == 16'd0)
            start_phase = PH_HDR_FIRST;
        else
            start_phase = PH_HDR_CONT;
    end

    assign cur_phase = (phase_reg == PH_NEW) ? start_phase : phase_reg;
    // header-only abandons any open report and starts at position zero
    assign pos_eff   = (phase_reg == PH_NEW && item_reg.kind) ? {POS_W{1'b0}} : pos_reg;
    assign pos_last  = (pos_eff == POS_LAST);
    assign pos_inc   = pos_eff + {{(POS_W-1){1'b0}}, 1'b1};
    assign pos_wrap  = pos_last ? {POS_W{1'b0}} : pos_inc;
    assign sent_inc  = sent_reg + 16'd1;
    assign msg_done  = (sent_inc >= item_reg.message_length);

    assign hdr_first = hdr_byte(pos_eff[2:0], item_reg.channel_id, item_reg.command,
                                item_reg.message_length);
    assign hdr_cont  = hdr_byte(pos_eff[2:0], item_reg.channel_id, seq_reg,
                                item_reg.message_length);

    assign res_valid = item_valid_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        seq_next        = seq_reg;
        sent_next       = sent_reg;
        res.report_byte = 8'd0;
        res.report_end  = pos_last;
        res.run_last    = 1'b0;
        case (cur_phase)
            PH_HDR_FIRST:
            begin
                res.report_byte = hdr_first;
                phase_next      = PH_HDR_FIRST;
                if (pos_eff[2:0] == HDR_LEN_LO)
                    phase_next = item_reg.kind ? PH_PAD : PH_DATA;
            end
            PH_HDR_CONT:
            begin
                res.report_byte = hdr_cont;
                phase_next      = PH_HDR_CONT;
                if (pos_eff[2:0] == HDR_CMD_SEQ)
                begin
                    seq_next   = seq_reg + 8'd1;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                res.report_byte = item_reg.data_byte;
                sent_next       = sent_inc;
                phase_next      = PH_DATA;
                if (msg_done && !pos_last)
                    phase_next = PH_PAD;
                else
                    res.run_last = 1'b1;
                if (msg_done && pos_last)
                begin
                    seq_next  = 8'd0;
                    sent_next = 16'd0;
                end
            end
            PH_PAD:
            begin
                res.report_byte = 8'd0;
                phase_next      = PH_PAD;
                if (pos_last)
                begin
                    res.run_last = 1'b1;
                    seq_next     = 8'd0;
                    sent_next    = 16'd0;
                end
            end
            default:
            begin
                res.report_byte = 8'd0;
            end
        endcase
        if (res.run_last)
            phase_next = PH_NEW;
        pos_next = pos_wrap;
        if (!fire)
        begin
            phase_next = phase_reg;
            pos_next   = pos_reg;
            seq_next   = seq_reg;
            sent_next  = sent_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= PH_NEW;
            pos_reg        <= {POS_W{1'b0}};
            seq_reg        <= 8'd0;
            sent_reg       <= 16'd0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= load;
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            seq_reg   <= seq_next;
            sent_reg  <= sent_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("report position out of range");

    a_cont_mid_msg: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR_CONT |-> sent_reg != 16'd0)
        else $error("continuation header outside a message");

    a_pad_open: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAD |-> pos_reg != {POS_W{1'b0}})
        else $error("padding with no open report");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.run_last && cur_phase == PH_PAD |=>
            pos_reg == {POS_W{1'b0}} && sent_reg == 16'd0 && seq_reg == 8'd0)
        else $error("state not cleared after padded report");
`endif

endmodule
`default_nettype wire

// File: rtl/hmrf_out_stage.sv
`default_nettype none
module hmrf_out_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hmrf_pkg::res_t in_res,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hmrf_pkg::res_t      out_res
);
    import hmrf_pkg::*;

    logic out_valid_reg;
    res_t res_reg;

    assign in_ready  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_ready)
            out_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            res_reg <= in_res;
    end

endmodule
`default_nettype wire

// File: rtl/hid_message_report_framer.sv
`default_nettype none
// Frames a message into REPORT_BYTES-byte HID reports, one report byte per
// output request. Each input request carries one payload byte (tuser = 0) or
// asks for a header-only report (tuser = 1). The first report of a message
// gets channel id (LSB first), command and big-endian length; continuation
// reports get channel id and a wrapping sequence number; the report holding
// the last payload byte is zero padded. Payload requests with length zero
// are taken and produce nothing. Output tlast marks the last byte of a
// report, tuser the last byte produced by the current input request. The
// output register emits one byte per cycle while m_axis_tready is high, and an
// input request produces 1 byte for a payload byte inside a report, 6 or 8
// when it opens a report, up to REPORT_BYTES when it closes a message or is
// header-only. The next request is taken in the cycle the previous one hands
// its last byte to the output register.
module hid_message_report_framer #(
    parameter int REPORT_BYTES = hmrf_pkg::REPORT_BYTES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // channel_id[31:0], command[39:32], message_length[55:40], data_byte[63:56]
    input  wire logic [63:0] s_axis_tdata,
    // kind
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // report_byte
    output logic [7:0]       m_axis_tdata,
    output logic             m_axis_tlast,
    // run_last
    output logic             m_axis_tuser
);
    import hmrf_pkg::*;

    item_t in_item;
    res_t  em_res, out_res;
    logic  em_valid, em_ready;

    assign in_item.kind           = s_axis_tuser;
    assign in_item.channel_id     = s_axis_tdata[31:0];
    assign in_item.command        = s_axis_tdata[39:32];
    assign in_item.message_length = s_axis_tdata[55:40];
    assign in_item.data_byte      = s_axis_tdata[63:56];

    hmrf_emitter #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (em_valid),
        .res_ready (em_ready),
        .res       (em_res)
    );

    hmrf_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (em_valid),
        .in_ready  (em_ready),
        .in_res    (em_res),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = out_res.report_byte;
    assign m_axis_tlast = out_res.report_end;
    assign m_axis_tuser = out_res.run_last;

endmodule
`default_nettype wire
